// ----- sv/spi_master_byte_exchange_macros.svh -----
// Assertion macros for the SPI master byte exchange block.
// Included by spi_mbx_core, the RTL file that carries concurrent checks; no other dependencies.
`ifndef SPI_MASTER_BYTE_EXCHANGE_MACROS_SVH
`define SPI_MASTER_BYTE_EXCHANGE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SPI_MBX_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SPI_MBX_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SPI_MBX_ASSERT(label, clk, rst, prop, msg)
`define SPI_MBX_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- sv/spi_mbx_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the SPI master byte exchange block.
// No dependencies; imported by every module of the block.
package spi_mbx_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_END   = 2'd3
  } spi_mbx_op_t;

  typedef enum logic [1:0] {
    CFG_CLOCK_POLARITY    = 2'd0,
    CFG_CLOCK_PHASE       = 2'd1,
    CFG_SELECT_IDLE_LEVEL = 2'd2,
    CFG_READ_FILL         = 2'd3
  } spi_mbx_cfg_idx_t;

  localparam int unsigned CNT_W      = 5;
  localparam logic [CNT_W-1:0] LAST_HALF = 5'd16;

  localparam logic       RST_CLOCK_POLARITY    = 1'b0;
  localparam logic       RST_CLOCK_PHASE       = 1'b0;
  localparam logic       RST_SELECT_IDLE_LEVEL = 1'b1;
  localparam logic [7:0] RST_READ_FILL         = 8'hFF;

  typedef struct packed {
    logic       sck;
    logic       mosi;
    logic       select_line;
    logic       busy_res;
    logic [7:0] rx_byte;
    logic       rx_valid;
  } spi_mbx_res_t;

  function automatic logic [7:0] rotl8(input logic [7:0] v);
    return {v[6:0], v[7]};
  endfunction

endpackage

// ----- sv/spi_mbx_core.sv -----
`timescale 1ns / 1ps
// Per-item step of the SPI master: configuration, shift and count state.
// Depends on spi_mbx_pkg and the assertion macro header.
`include "spi_master_byte_exchange_macros.svh"
module spi_mbx_core
  import spi_mbx_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data,
  input  logic         step,
  input  logic [1:0]   opcode,
  input  logic [7:0]   tx_byte,
  input  logic         miso,
  output spi_mbx_res_t res
);

  logic             clock_polarity;
  logic             clock_phase;
  logic             select_idle_level;
  logic [7:0]       read_fill;

  logic [7:0]       tx_shift, tx_shift_next;
  logic [7:0]       rx_shift, rx_shift_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             active, active_next;
  logic             selected, selected_next;
  logic             clock_level, clock_level_next;
  logic             out_level, out_level_next;
  logic [7:0]       rx_last, rx_last_next;
  logic             valid;
  logic [7:0]       src;
  logic             do_drive, do_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_polarity    <= RST_CLOCK_POLARITY;
      clock_phase       <= RST_CLOCK_PHASE;
      select_idle_level <= RST_SELECT_IDLE_LEVEL;
      read_fill         <= RST_READ_FILL;
    end else if (cfg_we) begin
      unique case (spi_mbx_cfg_idx_t'(cfg_index))
        CFG_CLOCK_POLARITY:    clock_polarity    <= cfg_data[0];
        CFG_CLOCK_PHASE:       clock_phase       <= cfg_data[0];
        CFG_SELECT_IDLE_LEVEL: select_idle_level <= cfg_data[0];
        CFG_READ_FILL:         read_fill         <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    tx_shift_next    = tx_shift;
    rx_shift_next    = rx_shift;
    cnt_next         = cnt;
    active_next      = active;
    selected_next    = selected;
    clock_level_next = clock_level;
    out_level_next   = out_level;
    rx_last_next     = rx_last;
    valid            = 1'b0;
    do_drive         = 1'b0;
    do_sample        = 1'b0;
    src = (spi_mbx_op_t'(opcode) == OP_WRITE) ? tx_byte : read_fill;
    if (!active) begin
      clock_level_next = clock_polarity;
      priority if (spi_mbx_op_t'(opcode) == OP_WRITE || spi_mbx_op_t'(opcode) == OP_READ) begin
        rx_shift_next = 8'h00;
        selected_next = 1'b1;
        active_next   = 1'b1;
        cnt_next      = '0;
        if (!clock_phase) begin
          out_level_next = src[7];
          tx_shift_next  = rotl8(src);
        end else begin
          tx_shift_next  = src;
        end
      end else if (spi_mbx_op_t'(opcode) == OP_END) begin
        selected_next = 1'b0;
      end else begin
      end
    end else begin
      if (cnt != '0) begin
        if (cnt[0]) begin
          clock_level_next = ~clock_polarity;
          do_drive         = clock_phase;
          do_sample        = ~clock_phase;
        end else begin
          clock_level_next = clock_polarity;
          do_drive         = ~clock_phase;
          do_sample        = clock_phase;
        end
      end
      if (do_drive) begin
        out_level_next = tx_shift[7];
        tx_shift_next  = rotl8(tx_shift);
      end
      if (do_sample) begin
        rx_shift_next = {rx_shift[6:0], miso};
      end
      if (cnt >= LAST_HALF) begin
        active_next  = 1'b0;
        cnt_next     = '0;
        rx_last_next = rx_shift_next;
        valid        = 1'b1;
      end else begin
        cnt_next = cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_shift    <= 8'h00;
      rx_shift    <= 8'h00;
      cnt         <= '0;
      active      <= 1'b0;
      selected    <= 1'b0;
      clock_level <= RST_CLOCK_POLARITY;
      out_level   <= 1'b0;
      rx_last     <= 8'h00;
    end else if (step) begin
      tx_shift    <= tx_shift_next;
      rx_shift    <= rx_shift_next;
      cnt         <= cnt_next;
      active      <= active_next;
      selected    <= selected_next;
      clock_level <= clock_level_next;
      out_level   <= out_level_next;
      rx_last     <= rx_last_next;
    end
  end

  always_comb begin
    res.sck         = clock_level_next;
    res.mosi        = out_level_next;
    res.select_line = selected_next ? ~select_idle_level : select_idle_level;
    res.busy_res    = active_next;
    res.rx_byte     = rx_last_next;
    res.rx_valid    = valid;
  end

  `SPI_MBX_ASSERT(a_cnt_range, clk, rst, cnt <= LAST_HALF, "half-period count out of range")
  `SPI_MBX_ASSERT(a_idle_cnt, clk, rst, !active |-> cnt == '0, "count not cleared while idle")
  `SPI_MBX_ASSERT(a_finish, clk, rst, (step && active && cnt == LAST_HALF) |=> !active, "byte did not finish")
  `SPI_MBX_ASSERT(a_valid_end, clk, rst, res.rx_valid |-> (active && !res.busy_res), "rx_valid without byte end")

endmodule

// ----- sv/spi_mbx_out.sv -----
`timescale 1ns / 1ps
// Output register of the SPI master: holds one result item until taken.
// Depends on spi_mbx_pkg.
module spi_mbx_out
  import spi_mbx_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  spi_mbx_res_t res_in,
  input  logic         take,
  output logic         full,
  output spi_mbx_res_t res_out
);

  logic full_next;

  always_comb begin
    full_next = full;
    if (load) begin
      full_next = 1'b1;
    end else if (take) begin
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ----- sv/spi_master_byte_exchange.sv -----
`timescale 1ns / 1ps
// SPI master byte exchange, modes 0 to 3, MSB first. Each input item is one half-period step:
// one item per cycle, each giving exactly one result item; the state step is a single
// combinational pass into the output register, so the rate is set only by the output side
// taking items. A byte takes one lead item plus sixteen half-period items after its command.
// Depends on spi_mbx_pkg, spi_mbx_core and spi_mbx_out.
module spi_master_byte_exchange
  import spi_mbx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] tx_byte, [8] miso, [15:9] zero
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] sck, [1] mosi, [2] select_line, [3] busy_res,
                                 // [11:4] rx_byte, [15:12] zero
  output logic        m_tuser    // [0] rx_valid
);

  spi_mbx_res_t res, res_q;
  logic         step;

  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  spi_mbx_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .opcode    (s_tuser),
    .tx_byte   (s_tdata[7:0]),
    .miso      (s_tdata[8]),
    .res       (res)
  );

  spi_mbx_out u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (step),
    .res_in  (res),
    .take    (m_tready),
    .full    (m_tvalid),
    .res_out (res_q)
  );

  assign m_tdata = {4'b0000, res_q.rx_byte, res_q.busy_res, res_q.select_line,
                    res_q.mosi, res_q.sck};
  assign m_tuser = res_q.rx_valid;

endmodule
